// ===== design/rc_serial_frame_decoder_defines.svh =====
// Assertion macros shared by the frame decoder RTL.
`ifndef RC_SERIAL_FRAME_DECODER_DEFINES_SVH
`define RC_SERIAL_FRAME_DECODER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RCSFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RCSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rcsfd_pkg.sv =====
`timescale 1ns / 1ps

package rcsfd_pkg;

  localparam logic [4:0]  FRAME_LAST    = 5'd31;
  localparam logic [4:0]  CHECK_LO_POS  = 5'd30;
  localparam logic [4:0]  CAPTURE_FIRST = 5'd14;
  localparam logic [4:0]  CAPTURE_END   = 5'd22;
  localparam int          CAPTURE_COUNT = 8;
  localparam logic [15:0] CHECK_INIT    = 16'hFFFF;
  localparam logic [7:0]  SYNC_RESET    = 8'h20;

  // Outcome of the byte being processed this cycle.
  typedef struct packed {
    logic        valid;
    logic [15:0] ch_one;
    logic [15:0] ch_two;
    logic [15:0] ch_three;
    logic [15:0] ch_four;
  } frame_result_t;

endpackage

// ===== design/rcsfd_frame_parser.sv =====
`timescale 1ns / 1ps

module rcsfd_frame_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             sync_value,
  output logic                   at_last,
  output rcsfd_pkg::frame_result_t frame
);
  import rcsfd_pkg::*;

  logic [4:0]  position;
  logic [4:0]  position_next;
  logic [15:0] check;
  logic [15:0] check_next;
  logic [7:0]  cap [CAPTURE_COUNT];
  logic [7:0]  check_lo;
  logic        hunting;
  logic        in_frame;
  logic        capture_hit;
  logic [2:0]  cap_idx;
  logic [15:0] rx_check;

  assign hunting     = (position == 5'd0);
  assign in_frame    = !hunting || (rx_byte == sync_value);
  assign at_last     = (position == FRAME_LAST);
  assign capture_hit = (position >= CAPTURE_FIRST) && (position < CAPTURE_END);
  // Slot within the capture window; only the low bits matter modulo 8.
  assign cap_idx     = position[2:0] - CAPTURE_FIRST[2:0];
  assign rx_check    = {rx_byte, check_lo};

  always_comb begin
    position_next = position;
    check_next    = check;
    if (step && in_frame) begin
      position_next = at_last ? 5'd0 : position + 5'd1;
      if (hunting) begin
        check_next = CHECK_INIT - {8'd0, rx_byte};
      end else if (position < CHECK_LO_POS) begin
        check_next = check - {8'd0, rx_byte};
      end else if (at_last) begin
        check_next = CHECK_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 5'd0;
      check    <= CHECK_INIT;
    end else begin
      position <= position_next;
      check    <= check_next;
    end
  end

  // Capture bytes and the check low byte carry no reset; each is written
  // within a frame before the last byte reads it.
  always_ff @(posedge clk) begin
    if (step && capture_hit) begin
      cap[cap_idx] <= rx_byte;
    end
    if (step && (position == CHECK_LO_POS)) begin
      check_lo <= rx_byte;
    end
  end

  always_comb begin
    frame.valid    = step && at_last && (rx_check == check);
    frame.ch_one   = {cap[1], cap[0]};
    frame.ch_two   = {cap[3], cap[2]};
    frame.ch_three = {cap[5], cap[4]};
    frame.ch_four  = {cap[7], cap[6]};
  end

endmodule

// ===== design/rc_serial_frame_decoder.sv =====
`timescale 1ns / 1ps

// Serial RC receiver frame decoder. Each input word is one received byte;
// a frame opens with a byte equal to sync_value, runs 32 bytes, and closes
// with a little-endian check word equal to 0xFFFF minus the sum of bytes 0
// to 29. A good frame yields one output word with the four channel values
// from bytes 14 to 21; a bad one yields nothing and the decoder hunts for
// sync again. A byte is taken every cycle unless input is held off: it
// lands in an input register, is parsed from there, and any result sits in
// an output register. Input is held off only when the closing byte of a
// frame meets a result still waiting at the output. sync_value resets to
// 0x20 and is written through the cfg port; the user must write it only
// while the decoder is idle, as the block itself does not enforce this.
module rc_serial_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  sync_value,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] channel_one,
  output logic [15:0] channel_two,
  output logic [15:0] channel_three,
  output logic [15:0] channel_four
);
  import rcsfd_pkg::*;

`include "rc_serial_frame_decoder_defines.svh"

  logic          sync_reg;
  logic [7:0]    sync_q;
  logic          byte_valid;
  logic          byte_valid_next;
  logic [7:0]    byte_q;
  logic          advance;
  logic          at_last;
  logic          out_valid_next;
  frame_result_t frame;

  assign cfg_ready = 1'b1;
  assign sync_reg  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_q <= SYNC_RESET;
    end else if (sync_reg) begin
      sync_q <= sync_value;
    end
  end

  // The closing byte waits while the output still holds an untaken result.
  assign advance  = byte_valid && !(at_last && out_valid && !out_ready);
  assign in_ready = !byte_valid || advance;

  assign byte_valid_next = (in_valid && in_ready) || (byte_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= byte_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  rcsfd_frame_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (byte_q),
    .sync_value (sync_q),
    .at_last    (at_last),
    .frame      (frame)
  );

  assign out_valid_next = frame.valid || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid) begin
      channel_one   <= frame.ch_one;
      channel_two   <= frame.ch_two;
      channel_three <= frame.ch_three;
      channel_four  <= frame.ch_four;
    end
  end

  `RCSFD_ASSERT_SAME(a_no_overwrite, frame.valid, !out_valid || out_ready,
    "frame result would overwrite a waiting word")
  `RCSFD_ASSERT_NEXT(a_byte_held, byte_valid && !advance,
    byte_valid && $stable(byte_q), "stalled byte lost or changed")
  `RCSFD_ASSERT_NEXT(a_frame_closes, advance && at_last, !at_last,
    "parser did not return to hunting after the last byte")
  `RCSFD_ASSERT_NEXT(a_result_shown, frame.valid, out_valid,
    "good frame did not reach the output")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rcsfd_pkg::*;

  localparam int TRAFFIC_BYTES  = 380;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 160;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_SYNC, FILL_RANDOM} fill_kind_t;
  typedef logic [7:0] frame_bytes_t [32];

  typedef struct packed {
    logic [15:0] one;
    logic [15:0] two;
    logic [15:0] three;
    logic [15:0] four;
  } channel_set_t;

  class channel_scoreboard;
    logic [7:0]   sync_byte;
    logic [4:0]   position;
    logic [15:0]  sum_check;
    logic [7:0]   chan_bytes [8];
    logic [7:0]   check_lo;
    channel_set_t pending_channels [$];
    int           errors;

    function new();
      sync_byte = SYNC_RESET;
      position  = '0;
      sum_check = CHECK_INIT;
      check_lo  = '0;
      errors    = 0;
      foreach (chan_bytes[i]) chan_bytes[i] = '0;
    endfunction

    function void set_sync(logic [7:0] v);
      sync_byte = v;
    endfunction

    // Parser step for one accepted byte; queues the channels of a good frame.
    function void take_byte(logic [7:0] b);
      channel_set_t c;
      if (position == 0 && b != sync_byte) return;
      if (position == 0) sum_check = CHECK_INIT - 16'(b);
      else if (position < CHECK_LO_POS) sum_check = sum_check - 16'(b);
      if (position >= CAPTURE_FIRST && position < CAPTURE_END)
        chan_bytes[3'(position - CAPTURE_FIRST)] = b;
      if (position == CHECK_LO_POS) check_lo = b;
      if (position == FRAME_LAST) begin
        if ({b, check_lo} == sum_check) begin
          c.one   = {chan_bytes[1], chan_bytes[0]};
          c.two   = {chan_bytes[3], chan_bytes[2]};
          c.three = {chan_bytes[5], chan_bytes[4]};
          c.four  = {chan_bytes[7], chan_bytes[6]};
          pending_channels.push_back(c);
        end
        position  = '0;
        sum_check = CHECK_INIT;
      end else begin
        position = position + 5'd1;
      end
    endfunction

    function void check_channels(logic [15:0] c1, logic [15:0] c2,
                                 logic [15:0] c3, logic [15:0] c4);
      channel_set_t e;
      if (pending_channels.size() == 0) begin
        $error("output word with no good frame pending: %h %h %h %h", c1, c2, c3, c4);
        errors++;
        return;
      end
      e = pending_channels.pop_front();
      if (c1 !== e.one) begin
        $error("channel_one: expected %h, got %h", e.one, c1);
        errors++;
      end
      if (c2 !== e.two) begin
        $error("channel_two: expected %h, got %h", e.two, c2);
        errors++;
      end
      if (c3 !== e.three) begin
        $error("channel_three: expected %h, got %h", e.three, c3);
        errors++;
      end
      if (c4 !== e.four) begin
        $error("channel_four: expected %h, got %h", e.four, c4);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  sync_value;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] channel_one;
  logic [15:0] channel_two;
  logic [15:0] channel_three;
  logic [15:0] channel_four;

  bit calm;
  bit hold_request;
  int idle_cycles;

  channel_scoreboard board = new();

  rc_serial_frame_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .sync_value    (sync_value),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_one   (channel_one),
    .channel_two   (channel_two),
    .channel_three (channel_three),
    .channel_four  (channel_four)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Handshakes seen here read pre-edge values; inputs only move at negedge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) board.set_sync(sync_value);
      if (out_valid && out_ready)
        board.check_channels(channel_one, channel_two, channel_three, channel_four);
      if (in_valid && in_ready) board.take_byte(rx_byte);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && !rst && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_bytes_t f, input int first, input int count);
    for (int i = first; i < first + count; i++) send_byte(f[i]);
  endtask

  // Let the parser run dry before touching the sync register.
  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_channels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_valid  = 1'b1;
    sync_value = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void seal_frame(ref frame_bytes_t f);
    logic [15:0] sum;
    sum = CHECK_INIT;
    for (int i = 0; i < 30; i++) sum = sum - 16'(f[i]);
    f[30] = sum[7:0];
    f[31] = sum[15:8];
  endfunction

  function automatic frame_bytes_t make_frame(input logic [7:0] sync, input fill_kind_t fill,
                                              input bit spoil);
    frame_bytes_t f;
    int pos;
    f[0] = sync;
    for (int i = 1; i < 30; i++) begin
      case (fill)
        FILL_ZERO: f[i] = 8'h00;
        FILL_ONES: f[i] = 8'hFF;
        FILL_SYNC: f[i] = ($urandom_range(0, 3) != 0) ? sync : 8'($urandom);
        default:   f[i] = 8'($urandom);
      endcase
    end
    seal_frame(f);
    if (spoil) begin
      pos = $urandom_range(1, 31);
      f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
    end
    return f;
  endfunction

  function automatic fill_kind_t pick_fill();
    case ($urandom_range(0, 7))
      0:       return FILL_ZERO;
      1:       return FILL_ONES;
      2:       return FILL_SYNC;
      default: return FILL_RANDOM;
    endcase
  endfunction

  // Mostly well-formed frames; some bad checks, stray bytes and cut-off frames.
  task automatic run_traffic(input logic [7:0] sync, input int budget);
    int sent;
    int kind;
    int n;
    frame_bytes_t f;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        f = make_frame(sync, pick_fill(), 1'b0);
        send_frame(f, 0, 32);
        sent += 32;
      end else if (kind == 7) begin
        f = make_frame(sync, pick_fill(), 1'b1);
        send_frame(f, 0, 32);
        sent += 32;
      end else if (kind == 8) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
        sent += n;
      end else begin
        n = $urandom_range(1, 31);
        f = make_frame(sync, pick_fill(), 1'b0);
        send_frame(f, 0, n);
        sent += n;
      end
    end
  endtask

  initial begin
    frame_bytes_t f;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    sync_value   = SYNC_RESET;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // stray bytes while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_RESET ^ 8'h01);

    // extreme channel values, with sync bytes scattered through the payload
    f = make_frame(SYNC_RESET, FILL_SYNC, 1'b0);
    f[14] = 8'h00; f[15] = 8'h00;
    f[16] = 8'hFF; f[17] = 8'hFF;
    f[18] = 8'hFF; f[19] = 8'h00;
    f[20] = 8'h00; f[21] = 8'hFF;
    seal_frame(f);
    send_frame(f, 0, 32);

    // bad check, then a good frame straight after it
    f = make_frame(SYNC_RESET, FILL_RANDOM, 1'b1);
    send_frame(f, 0, 32);
    f = make_frame(SYNC_RESET, FILL_ONES, 1'b0);
    send_frame(f, 0, 32);

    // sync changed halfway through a frame: the open frame runs on
    f = make_frame(SYNC_RESET, FILL_ZERO, 1'b0);
    send_frame(f, 0, 16);
    settle();
    write_sync(8'h00);
    send_frame(f, 16, 16);
    send_byte(SYNC_RESET);
    f = make_frame(8'h00, FILL_RANDOM, 1'b0);
    send_frame(f, 0, 32);

    settle();
    write_sync(8'hFF);
    hold_request = 1'b1;
    run_traffic(8'hFF, TRAFFIC_BYTES);

    settle();
    sync_value = 8'($urandom);
    write_sync(sync_value);
    run_traffic(sync_value, TRAFFIC_BYTES);

    settle();
    write_sync(8'h00);
    run_traffic(8'h00, TRAFFIC_BYTES);

    settle();
    write_sync(8'h5A);
    run_traffic(8'h5A, TRAFFIC_BYTES);

    settle();
    write_sync(SYNC_RESET);
    calm = 1'b1;
    run_traffic(SYNC_RESET, TRAFFIC_BYTES);

    settle();
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== rc_serial_frame_decoder.f =====
+incdir+design
design/rcsfd_pkg.sv
design/rcsfd_frame_parser.sv
design/rc_serial_frame_decoder.sv
test/tb_top.sv
